[src/ldom_pkg.sv]
// Shared types, constants and helpers for the last-day-of-month pipeline.
package ldom_pkg;

	// Mode codes of an input word
	localparam logic MODE_DAYS   = 1'b0;
	localparam logic MODE_MICROS = 1'b1;

	// Time scale
	localparam longint unsigned SEC_PER_DAY = 64'd86400;
	localparam longint unsigned US_PER_SEC  = 64'd1000000;
	localparam longint unsigned US_PER_DAY  = SEC_PER_DAY * US_PER_SEC;

	// Microsecond to day split: a day in microseconds is an odd part shifted left
	localparam int unsigned DAY_SH  = 13;
	localparam int unsigned REM_W   = 38;
	localparam int unsigned QDAY_W  = 27;
	localparam longint unsigned US_DAY_ODD = US_PER_DAY >> DAY_SH;
	localparam int unsigned RCP_DAY_SH = 64;
	localparam logic [27:0] RCP_US_DAY = 28'((65'd1 << RCP_DAY_SH) / 65'(US_PER_DAY));

	// Gregorian 400-year cycle
	localparam int unsigned DAYS_PER_ERA  = 146097;
	localparam int unsigned DAYS_PER_100Y = 36524;
	localparam int unsigned DAYS_PER_4Y   = 1460;
	localparam int unsigned DAYS_PER_YEAR = 365;
	localparam int unsigned YEARS_PER_CENT = 100;
	localparam int unsigned EPOCH_SHIFT   = 719468;
	localparam int unsigned ERA_BIAS      = 14700;
	localparam logic [32:0] ERA_OFS =
		33'(longint'(EPOCH_SHIFT) + longint'(ERA_BIAS) * longint'(DAYS_PER_ERA));
	localparam int unsigned ERA_SH  = 48;
	localparam logic [30:0] RCP_ERA = 31'((64'd1 << ERA_SH) / 64'(DAYS_PER_ERA));

	localparam int unsigned DOE_W = 18;
	localparam int unsigned DOY_W = 9;
	localparam int unsigned YOE_W = 9;

	// Exact reciprocals for narrow operands: ceil(2^k / d)
	localparam int unsigned RCP_4Y_SH  = 29;
	localparam logic [18:0] RCP_4Y     =
		19'(((64'd1 << RCP_4Y_SH) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));
	localparam int unsigned RCP_YEAR_SH = 27;
	localparam logic [18:0] RCP_YEAR   =
		19'(((64'd1 << RCP_YEAR_SH) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));
	localparam int unsigned RCP_CENT_SH = 16;
	localparam logic [9:0]  RCP_CENT   =
		10'(((64'd1 << RCP_CENT_SH) + 64'(YEARS_PER_CENT) - 64'd1) / 64'(YEARS_PER_CENT));
	localparam int unsigned MONTH_DIV   = 153;
	localparam int unsigned RCP_MON_SH  = 19;
	localparam logic [11:0] RCP_MON    =
		12'(((64'd1 << RCP_MON_SH) + 64'(MONTH_DIV) - 64'd1) / 64'(MONTH_DIV));

	typedef struct packed {
		logic               mode;
		logic signed [63:0] value;
		logic               is_null;
		logic               last_row;
	} row_t;

	typedef struct packed {
		logic signed [31:0] result_days;
		logic               result_null;
		logic               last_row_out;
	} res_t;

	typedef struct packed {
		logic signed [31:0] days;
		logic               is_null;
		logic               last_row;
	} day_t;

	typedef struct packed {
		logic [DOE_W-1:0] doe;
		day_t             day;
	} doe_t;

	// Day of a March-based year on which month mp ends
	function automatic logic [DOY_W-1:0] month_end_doy(input logic [3:0] mp,
		input logic leap);
		logic [DOY_W-1:0] e;
		unique case (mp)
			4'd0:    e = 9'd30;
			4'd1:    e = 9'd60;
			4'd2:    e = 9'd91;
			4'd3:    e = 9'd121;
			4'd4:    e = 9'd152;
			4'd5:    e = 9'd183;
			4'd6:    e = 9'd213;
			4'd7:    e = 9'd244;
			4'd8:    e = 9'd274;
			4'd9:    e = 9'd305;
			4'd10:   e = 9'd336;
			4'd11:   e = leap ? 9'd365 : 9'd364;
			default: e = 9'd0;
		endcase
		return e;
	endfunction

endpackage

[src/last_day_of_month_days.sv]
// Top level: rows in, last day of the row's month out, 16-stage pipeline.
//
// Input channel row_valid / row_stall / row carries one word per row: a mode
// (day count or microsecond timestamp), the 64-bit value, a null flag and the
// batch end marker. Output channel res_valid / res_stall / res returns one word
// per row, in order: the day count of the last day of that month, a null flag
// (null input, or a result beyond the signed 32-bit range) and the batch marker.
// A word moves when valid is high and stall is low at a rising edge of clk.
//
// The pipeline takes one row every cycle while res_stall is low. The depth
// comes from three reciprocal multiply and correct steps (microseconds to days,
// days to 400-year cycle, cycle day to year and month), each spread over its
// own stages.
//
// arst_n clears every stage valid bit at once; the block is ready in the first
// cycle after reset. While res_stall is high the result word holds, the stages
// behind it keep closing up bubbles, and row_stall rises only once every stage
// holds a word.
module last_day_of_month_days
	import ldom_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic row_valid,
	output logic row_stall,
	input  row_t row,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic day_valid, day_stall;
	day_t day;
	logic doe_valid, doe_stall;
	doe_t doe;

	ldom_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.row       (row),
		.day_valid (day_valid),
		.day_stall (day_stall),
		.day       (day)
	);

	ldom_era u_era (
		.clk       (clk),
		.arst_n    (arst_n),
		.day_valid (day_valid),
		.day_stall (day_stall),
		.day       (day),
		.doe_valid (doe_valid),
		.doe_stall (doe_stall),
		.doe       (doe)
	);

	ldom_month u_month (
		.clk       (clk),
		.arst_n    (arst_n),
		.doe_valid (doe_valid),
		.doe_stall (doe_stall),
		.doe       (doe),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

[src/ldom_days.sv]
// Stages 1 to 5: turn a row into a signed day count since the epoch.
module ldom_days
	import ldom_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic row_valid,
	output logic row_stall,
	input  row_t row,
	output logic day_valid,
	input  logic day_stall,
	output day_t day
);

	typedef struct packed {
		logic        mode;
		logic        neg;
		logic [31:0] d32;
		logic        is_null;
		logic        last_row;
	} tag_t;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	logic [63:0]       a_s1;
	tag_t              tag_s1, tag_s2, tag_s3, tag_s4;
	logic [QDAY_W-1:0] qe_s2, qe_s3, q_s4;
	logic [REM_W-1:0]  rlo_s2, r_s3;
	logic              frac_s4;
	day_t              day_s5;

	logic [63:0]       a_abs;
	logic [59:0]       hp;
	logic [50:0]       qp;
	logic [REM_W-1:0]  rem;
	logic              ge, frac;
	logic [31:0]       qx, days_c;

	always_comb begin
		adv_s5 = !vld_s5 || !day_stall;
		adv_s4 = !vld_s4 || adv_s5;
		adv_s3 = !vld_s3 || adv_s4;
		adv_s2 = !vld_s2 || adv_s3;
		adv_s1 = !vld_s1 || adv_s2;
	end
	assign row_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= row_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
		end
	end

	// Work on the magnitude of the microsecond count
	assign a_abs = row.value[63] ? (~row.value + 64'd1) : row.value;

	// Quotient estimate from the high word, low by at most one
	assign hp = 60'(a_s1[63:32]) * 60'(RCP_US_DAY);

	// Remainder fits below two days, so low bits suffice
	assign qp  = 51'(qe_s2) * 51'(US_DAY_ODD);
	assign rem = rlo_s2 - {qp[REM_W-DAY_SH-1:0], {DAY_SH{1'b0}}};

	assign ge   = r_s3 >= REM_W'(US_PER_DAY);
	assign frac = ge ? (r_s3 >= REM_W'(US_PER_DAY + US_PER_SEC))
		: (r_s3 >= REM_W'(US_PER_SEC));

	// Negative side: truncate to seconds, then floor to days
	always_comb begin
		qx = {{(32-QDAY_W){1'b0}}, q_s4};
		if (tag_s4.mode == MODE_MICROS) begin
			days_c = tag_s4.neg ? (~qx + {31'd0, ~frac_s4}) : qx;
		end else begin
			days_c = tag_s4.d32;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			a_s1           <= a_abs;
			tag_s1.mode    <= row.mode;
			tag_s1.neg     <= row.value[63];
			tag_s1.d32     <= row.value[31:0];
			tag_s1.is_null <= row.is_null;
			tag_s1.last_row <= row.last_row;
		end
		if (adv_s2) begin
			qe_s2  <= hp[RCP_DAY_SH-32+QDAY_W-1:RCP_DAY_SH-32];
			rlo_s2 <= a_s1[REM_W-1:0];
			tag_s2 <= tag_s1;
		end
		if (adv_s3) begin
			qe_s3  <= qe_s2;
			r_s3   <= rem;
			tag_s3 <= tag_s2;
		end
		if (adv_s4) begin
			q_s4    <= qe_s3 + QDAY_W'(ge);
			frac_s4 <= frac;
			tag_s4  <= tag_s3;
		end
		if (adv_s5) begin
			day_s5.days     <= days_c;
			day_s5.is_null  <= tag_s4.is_null;
			day_s5.last_row <= tag_s4.last_row;
		end
	end

	assign day_valid = vld_s5;
	assign day       = day_s5;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (r_s3 < REM_W'(2 * US_PER_DAY)))
		else $error("day remainder beyond one correction step");

endmodule

[src/ldom_era.sv]
// Stages 6 to 9: reduce a day count to its day within the 400-year cycle.
module ldom_era
	import ldom_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic day_valid,
	output logic day_stall,
	input  day_t day,
	output logic doe_valid,
	input  logic doe_stall,
	output doe_t doe
);

	logic vld_s6, vld_s7, vld_s8, vld_s9;
	logic adv_s6, adv_s7, adv_s8, adv_s9;

	logic [32:0]      u_s6;
	logic [15:0]      qe_s7;
	logic [18:0]      ulo_s7, r_s8;
	day_t             day_s6, day_s7, day_s8;
	doe_t             doe_s9;

	logic [63:0]      up;
	logic [33:0]      ep;
	logic [DOE_W-1:0] doe_c;

	always_comb begin
		adv_s9 = !vld_s9 || !doe_stall;
		adv_s8 = !vld_s8 || adv_s9;
		adv_s7 = !vld_s7 || adv_s8;
		adv_s6 = !vld_s6 || adv_s7;
	end
	assign day_stall = !adv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv_s6) vld_s6 <= day_valid;
			if (adv_s7) vld_s7 <= vld_s6;
			if (adv_s8) vld_s8 <= vld_s7;
			if (adv_s9) vld_s9 <= vld_s8;
		end
	end

	// Era quotient estimate, low by at most one
	assign up = 64'(u_s6) * 64'(RCP_ERA);
	assign ep = 34'(qe_s7) * 34'(DAYS_PER_ERA);
	assign doe_c = (r_s8 >= 19'(DAYS_PER_ERA)) ? DOE_W'(r_s8 - 19'(DAYS_PER_ERA))
		: r_s8[DOE_W-1:0];

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			// Bias by whole eras so the shifted count stays positive
			u_s6   <= {day.days[31], day.days} + ERA_OFS;
			day_s6 <= day;
		end
		if (adv_s7) begin
			qe_s7  <= up[ERA_SH+15:ERA_SH];
			ulo_s7 <= u_s6[18:0];
			day_s7 <= day_s6;
		end
		if (adv_s8) begin
			r_s8   <= ulo_s7 - ep[18:0];
			day_s8 <= day_s7;
		end
		if (adv_s9) begin
			doe_s9.doe <= doe_c;
			doe_s9.day <= day_s8;
		end
	end

	assign doe_valid = vld_s9;
	assign doe       = doe_s9;

	a_era_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> (r_s8 < 19'(2 * DAYS_PER_ERA)))
		else $error("era remainder beyond one correction step");

endmodule

[src/ldom_month.sv]
// Stages 10 to 16: find the month of the cycle day and its last day count.
module ldom_month
	import ldom_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic doe_valid,
	output logic doe_stall,
	input  doe_t doe,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic adv_s10, adv_s11, adv_s12, adv_s13, adv_s14, adv_s15, adv_s16;

	doe_t             w_s10, w_s11, w_s12, w_s13;
	day_t             day_s14, day_s15;
	logic [6:0]       f_s10;
	logic [2:0]       c_s10;
	logic             top_s10;
	logic [DOE_W-1:0] n_s11;
	logic [YOE_W-1:0] yoe_s12;
	logic [DOE_W-1:0] yb_s13;
	logic             leap_s13, leap_s14, leap_s15;
	logic [DOY_W-1:0] doy_s14, doy_s15;
	logic [3:0]       mp_s15;
	res_t             res_s16;

	logic [36:0]      fp, yp;
	logic [18:0]      hq;
	logic [9:0]       t;
	logic             leap;
	logic [10:0]      mx;
	logic [22:0]      mq;
	logic [32:0]      sum;
	logic             ovf;

	always_comb begin
		adv_s16 = !vld_s16 || !res_stall;
		adv_s15 = !vld_s15 || adv_s16;
		adv_s14 = !vld_s14 || adv_s15;
		adv_s13 = !vld_s13 || adv_s14;
		adv_s12 = !vld_s12 || adv_s13;
		adv_s11 = !vld_s11 || adv_s12;
		adv_s10 = !vld_s10 || adv_s11;
	end
	assign doe_stall = !adv_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
		end else begin
			if (adv_s10) vld_s10 <= doe_valid;
			if (adv_s11) vld_s11 <= vld_s10;
			if (adv_s12) vld_s12 <= vld_s11;
			if (adv_s13) vld_s13 <= vld_s12;
			if (adv_s14) vld_s14 <= vld_s13;
			if (adv_s15) vld_s15 <= vld_s14;
			if (adv_s16) vld_s16 <= vld_s15;
		end
	end

	assign fp = 37'(doe.doe) * 37'(RCP_4Y);
	assign yp = 37'(n_s11) * 37'(RCP_YEAR);
	assign hq = 19'(yoe_s12) * 19'(RCP_CENT);

	// Year after yoe is the one holding February of this March-based year
	assign t    = 10'(yoe_s12) + 10'd1;
	assign leap = (t[1:0] == 2'b00) && (t != 10'(YEARS_PER_CENT))
		&& (t != 10'(2 * YEARS_PER_CENT)) && (t != 10'(3 * YEARS_PER_CENT));

	assign mx = 11'(doy_s14) * 11'd5 + 11'd2;
	assign mq = 23'(mx) * 23'(RCP_MON);

	// Advance from the current day to the month's last day
	assign sum = {day_s15.days[31], day_s15.days}
		+ 33'(month_end_doy(mp_s15, leap_s15)) - 33'(doy_s15);
	assign ovf = sum[32] ^ sum[31];

	always_ff @(posedge clk) begin
		if (adv_s10) begin
			f_s10   <= fp[RCP_4Y_SH+6:RCP_4Y_SH];
			c_s10   <= 3'(doe.doe >= DOE_W'(DAYS_PER_100Y))
				+ 3'(doe.doe >= DOE_W'(2 * DAYS_PER_100Y))
				+ 3'(doe.doe >= DOE_W'(3 * DAYS_PER_100Y))
				+ 3'(doe.doe >= DOE_W'(4 * DAYS_PER_100Y));
			top_s10 <= doe.doe == DOE_W'(DAYS_PER_ERA - 1);
			w_s10   <= doe;
		end
		if (adv_s11) begin
			n_s11 <= w_s10.doe - DOE_W'(f_s10) + DOE_W'(c_s10) - DOE_W'(top_s10);
			w_s11 <= w_s10;
		end
		if (adv_s12) begin
			yoe_s12 <= yp[RCP_YEAR_SH+YOE_W-1:RCP_YEAR_SH];
			w_s12   <= w_s11;
		end
		if (adv_s13) begin
			yb_s13   <= DOE_W'(yoe_s12) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe_s12[8:2])
				- DOE_W'(hq[RCP_CENT_SH+1:RCP_CENT_SH]);
			leap_s13 <= leap;
			w_s13    <= w_s12;
		end
		if (adv_s14) begin
			doy_s14  <= DOY_W'(w_s13.doe - yb_s13);
			leap_s14 <= leap_s13;
			day_s14  <= w_s13.day;
		end
		if (adv_s15) begin
			mp_s15   <= mq[RCP_MON_SH+3:RCP_MON_SH];
			doy_s15  <= doy_s14;
			leap_s15 <= leap_s14;
			day_s15  <= day_s14;
		end
		if (adv_s16) begin
			// Drop the value of null rows and of sums past the signed range
			res_s16.result_days  <= (day_s15.is_null || ovf) ? 32'sd0 : sum[31:0];
			res_s16.result_null  <= day_s15.is_null || ovf;
			res_s16.last_row_out <= day_s15.last_row;
		end
	end

	assign res_valid = vld_s16;
	assign res       = res_s16;

	a_yoe_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s12 |-> (yoe_s12 < YOE_W'(4 * YEARS_PER_CENT)))
		else $error("year of era out of range");

	a_mp_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s15 |-> (mp_s15 <= 4'd11))
		else $error("month index out of range");

	a_doy_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s15 |-> (doy_s15 <= month_end_doy(mp_s15, leap_s15)))
		else $error("day of year past the end of its month");

endmodule
